@@ hw/rtl/utld_pkg.sv @@
// types and constants shared by the utf-8 text layout decoder
// no dependencies; imported by every module of the block

package utld_pkg;

  typedef enum logic [1:0] {
    GLYPH_ASCII_LARGE = 2'd0,
    GLYPH_ASCII_SMALL = 2'd1,
    GLYPH_SPECIAL     = 2'd2,
    GLYPH_WIDE        = 2'd3
  } glyph_kind_t;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned COL_W   = 16;
  localparam int unsigned WIDTH_W = 16;

  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_CODE  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_CODE  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_CODE  = 8'hF0;

  localparam logic [CP_W-1:0] CP_INVALID    = 21'h00003F;
  localparam logic [CP_W-1:0] CP_ASCII_LIM  = 21'h000080;
  localparam logic [CP_W-1:0] CP_FW_COMMA   = 21'h00FF0C;
  localparam logic [CP_W-1:0] CP_IDEO_STOP  = 21'h003002;
  localparam logic [CP_W-1:0] CP_IDEO_COMMA = 21'h003001;

  localparam logic [COL_W-1:0] ADV_LARGE = 16'd9;
  localparam logic [COL_W-1:0] ADV_SMALL = 16'd12;
  localparam logic [COL_W-1:0] ADV_WIDE  = 16'd17;

  localparam logic [WIDTH_W-1:0] ADD_ASCII = 16'd9;
  localparam logic [WIDTH_W-1:0] ADD_WIDE  = 16'd17;

  // decoded item between the byte stage and the layout stage
  typedef struct packed {
    logic              done;
    logic              first;
    logic              last;
    logic [COL_W-1:0]  start_x;
    logic [CP_W-1:0]   cp;
  } dec_item_t;

  typedef struct packed {
    glyph_kind_t        kind;
    logic [COL_W-1:0]   cursor_nxt;
    logic [WIDTH_W-1:0] sum_nxt;
    logic [WIDTH_W-1:0] text_width;
  } layout_t;

endpackage

@@ hw/rtl/utld_byte_dec.sv @@
// utf-8 byte decoder: merges one byte into the open sequence state
// depends on utld_pkg

module utld_byte_dec (
  input  logic [7:0]                  text_byte,
  input  logic                        first_byte,
  input  logic [utld_pkg::COL_W-1:0]  start_x,
  input  logic                        last_byte,
  input  logic [utld_pkg::CP_W-1:0]   part_cp,
  input  logic [1:0]                  remain,
  output logic [utld_pkg::CP_W-1:0]   part_cp_nxt,
  output logic [1:0]                  remain_nxt,
  output utld_pkg::dec_item_t         item
);
  import utld_pkg::*;

  logic [CP_W-1:0] pc;
  logic [1:0]      rem;
  logic [CP_W-1:0] pc_new;
  logic [1:0]      rem_new;
  logic            done;
  logic [CP_W-1:0] cp;

  always_comb begin
    pc      = first_byte ? '0 : part_cp;
    rem     = first_byte ? 2'd0 : remain;
    pc_new  = pc;
    rem_new = rem;
    done    = 1'b0;
    cp      = '0;

    if (rem != 2'd0) begin
      pc_new  = {pc[CP_W-7:0], text_byte[5:0]};
      rem_new = rem - 2'd1;
      if (rem_new == 2'd0) begin
        cp   = pc_new;
        done = 1'b1;
      end
    end else if (!text_byte[7]) begin
      cp   = {{(CP_W-8){1'b0}}, text_byte};
      done = 1'b1;
    end else if ((text_byte & LEAD2_MASK) == LEAD2_CODE) begin
      pc_new  = {{(CP_W-5){1'b0}}, text_byte[4:0]};
      rem_new = 2'd1;
    end else if ((text_byte & LEAD3_MASK) == LEAD3_CODE) begin
      pc_new  = {{(CP_W-4){1'b0}}, text_byte[3:0]};
      rem_new = 2'd2;
    end else if ((text_byte & LEAD4_MASK) == LEAD4_CODE) begin
      pc_new  = {{(CP_W-3){1'b0}}, text_byte[2:0]};
      rem_new = 2'd3;
    end else begin
      cp   = CP_INVALID;
      done = 1'b1;
    end

    // cut-short sequence: pad missing continuation bits with zeros
    if (!done && last_byte && rem_new != 2'd0) begin
      case (rem_new)
        2'd1:    cp = {pc_new[CP_W-7:0], 6'd0};
        2'd2:    cp = {pc_new[CP_W-13:0], 12'd0};
        default: cp = {pc_new[CP_W-19:0], 18'd0};
      endcase
      rem_new = 2'd0;
      done    = 1'b1;
    end

    if (done) begin
      pc_new = '0;
    end
  end

  assign part_cp_nxt  = pc_new;
  assign remain_nxt   = rem_new;
  assign item.done    = done;
  assign item.first   = first_byte;
  assign item.last    = last_byte;
  assign item.start_x = start_x;
  assign item.cp      = cp;

endmodule

@@ hw/rtl/utld_layout.sv @@
// glyph classification, cursor advance and saturating width sum
// depends on utld_pkg

module utld_layout (
  input  logic [utld_pkg::CP_W-1:0]    cp,
  input  logic                         large_font,
  input  logic [utld_pkg::COL_W-1:0]   cursor,
  input  logic [utld_pkg::WIDTH_W-1:0] sum,
  output utld_pkg::layout_t            lay
);
  import utld_pkg::*;

  logic               is_ascii;
  logic [COL_W-1:0]   adv;
  logic [WIDTH_W-1:0] add;
  logic [WIDTH_W:0]   sum_ext;
  logic [WIDTH_W-1:0] sum_sat;

  always_comb begin
    is_ascii = cp < CP_ASCII_LIM;
    if (is_ascii) begin
      lay.kind = large_font ? GLYPH_ASCII_LARGE : GLYPH_ASCII_SMALL;
      adv      = large_font ? ADV_LARGE : ADV_SMALL;
      add      = ADD_ASCII;
    end else begin
      if (cp == CP_FW_COMMA || cp == CP_IDEO_STOP || cp == CP_IDEO_COMMA) begin
        lay.kind = GLYPH_SPECIAL;
      end else begin
        lay.kind = GLYPH_WIDE;
      end
      adv = ADV_WIDE;
      add = ADD_WIDE;
    end
    sum_ext        = {1'b0, sum} + {1'b0, add};
    sum_sat        = sum_ext[WIDTH_W] ? '1 : sum_ext[WIDTH_W-1:0];
    lay.sum_nxt    = sum_sat;
    lay.text_width = (sum_sat == '0) ? '0 : sum_sat - WIDTH_W'(1);
    lay.cursor_nxt = cursor + adv;
  end

endmodule

@@ hw/rtl/utf8_text_layout_decoder_core.sv @@
// utf-8 text layout decoder, top level; depends on utld_pkg, utld_byte_dec and
// utld_layout. Takes one text byte per cycle while in_stall is low and gives
// at most one result item per byte: codepoint, draw column, glyph kind,
// running width and end flag. Throughput is one item per clock cycle while
// out_stall is low. An accepted byte is decoded against the open sequence
// into a stage register, and the layout stage places the glyph (cursor and
// width sum) into the output register. Bytes that only open or extend a
// sequence give no result. cfg_ready is high only while both stages are empty.

module utf8_text_layout_decoder_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_text_byte,
  input  logic                               in_first_byte,
  input  logic signed [utld_pkg::COL_W-1:0]  in_start_x,
  input  logic                               in_last_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [utld_pkg::CP_W-1:0]          out_codepoint,
  output logic signed [utld_pkg::COL_W-1:0]  out_draw_x,
  output logic [1:0]                         out_glyph_kind,
  output logic [utld_pkg::WIDTH_W-1:0]       out_text_width,
  output logic                               out_end_of_text,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_large_ascii_font_present
);
  import utld_pkg::*;

  logic               font_r;
  logic [CP_W-1:0]    part_cp_r, part_cp_nxt;
  logic [1:0]         remain_r, remain_nxt;
  logic               s1_valid_r;
  dec_item_t          s1_r, dec_item;
  logic [COL_W-1:0]   cursor_r;
  logic [WIDTH_W-1:0] sum_r;
  logic [COL_W-1:0]   cur_eff;
  logic [WIDTH_W-1:0] sum_eff;
  layout_t            lay;
  logic               out_valid_r;
  logic [CP_W-1:0]    out_cp_r;
  logic [COL_W-1:0]   out_x_r;
  glyph_kind_t        out_kind_r;
  logic [WIDTH_W-1:0] out_width_r;
  logic               out_eot_r;
  logic               adv_out;
  logic               load_s1;
  logic               in_accept;

  assign adv_out   = !out_valid_r || !out_stall;
  assign load_s1   = adv_out || !s1_valid_r;
  assign in_stall  = s1_valid_r && !adv_out;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = !s1_valid_r && !out_valid_r;

  utld_byte_dec u_dec (
    .text_byte   (in_text_byte),
    .first_byte  (in_first_byte),
    .start_x     (in_start_x),
    .last_byte   (in_last_byte),
    .part_cp     (part_cp_r),
    .remain      (remain_r),
    .part_cp_nxt (part_cp_nxt),
    .remain_nxt  (remain_nxt),
    .item        (dec_item)
  );

  assign cur_eff = s1_r.first ? s1_r.start_x : cursor_r;
  assign sum_eff = s1_r.first ? '0 : sum_r;

  utld_layout u_lay (
    .cp         (s1_r.cp),
    .large_font (font_r),
    .cursor     (cur_eff),
    .sum        (sum_eff),
    .lay        (lay)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_r      <= 1'b0;
      part_cp_r   <= '0;
      remain_r    <= 2'd0;
      s1_valid_r  <= 1'b0;
      cursor_r    <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        font_r <= cfg_large_ascii_font_present;
      end
      if (in_accept) begin
        part_cp_r <= part_cp_nxt;
        remain_r  <= remain_nxt;
      end
      if (load_s1) begin
        s1_valid_r <= in_accept;
      end
      if (adv_out) begin
        out_valid_r <= s1_valid_r && s1_r.done;
        if (s1_valid_r) begin
          cursor_r <= s1_r.done ? lay.cursor_nxt : cur_eff;
          sum_r    <= s1_r.done ? lay.sum_nxt : sum_eff;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load_s1 && in_accept) begin
      s1_r <= dec_item;
    end
    if (adv_out && s1_valid_r && s1_r.done) begin
      out_cp_r    <= s1_r.cp;
      out_x_r     <= cur_eff;
      out_kind_r  <= lay.kind;
      out_width_r <= lay.text_width;
      out_eot_r   <= s1_r.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_codepoint   = out_cp_r;
  assign out_draw_x      = out_x_r;
  assign out_glyph_kind  = out_kind_r;
  assign out_text_width  = out_width_r;
  assign out_end_of_text = out_eot_r;

  a_last_closes_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_last_byte |=> remain_r == 2'd0)
    else $error("sequence left open after last byte");

  a_done_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_r.done && adv_out |=> out_valid_r)
    else $error("decoded item lost before output register");

  a_ascii_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == GLYPH_ASCII_LARGE || out_kind_r == GLYPH_ASCII_SMALL)
    |-> out_cp_r < CP_ASCII_LIM)
    else $error("ascii glyph kind on non-ascii codepoint");

endmodule

@@ tb/tb.sv @@
// self-checking testbench for utf8_text_layout_decoder_core
// depends on utld_pkg and the decoder rtl; predicts each glyph result from the byte stream
// and checks every result item against it, with and without random idling on both channels
`timescale 1ns / 100ps

module tb;
  import utld_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0]    codepoint;
    logic [COL_W-1:0]   draw_x;
    glyph_kind_t        glyph_kind;
    logic [WIDTH_W-1:0] text_width;
    logic               end_of_text;
  } glyph_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_text_byte;
  logic              in_first_byte;
  logic [COL_W-1:0]  in_start_x;
  logic              in_last_byte;
  logic              out_valid;
  logic              out_stall;
  logic [CP_W-1:0]   out_codepoint;
  logic [COL_W-1:0]  out_draw_x;
  logic [1:0]        out_glyph_kind;
  logic [WIDTH_W-1:0] out_text_width;
  logic              out_end_of_text;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_large_ascii_font_present;

  // layout state mirrored from the byte stream
  logic               font_large = 1'b0;
  logic [COL_W-1:0]   cursor_col = '0;
  logic [CP_W-1:0]    partial_cp = '0;
  logic [1:0]         bytes_left = '0;
  logic [WIDTH_W-1:0] width_total = '0;

  glyph_result_t expected_glyphs[$];

  int  error_count = 0;
  int  bytes_sent = 0;
  int  glyphs_checked = 0;
  int  input_stall_cycles = 0;
  bit  tx_gaps = 1'b0;
  bit  rx_gaps = 1'b0;
  int  hold_off_request = 0;
  int  stall_left = 0;

  utf8_text_layout_decoder_core u_top (
    .clk                          (clk),
    .rst_n                        (rst_n),
    .in_valid                     (in_valid),
    .in_stall                     (in_stall),
    .in_text_byte                 (in_text_byte),
    .in_first_byte                (in_first_byte),
    .in_start_x                   (in_start_x),
    .in_last_byte                 (in_last_byte),
    .out_valid                    (out_valid),
    .out_stall                    (out_stall),
    .out_codepoint                (out_codepoint),
    .out_draw_x                   (out_draw_x),
    .out_glyph_kind               (out_glyph_kind),
    .out_text_width               (out_text_width),
    .out_end_of_text              (out_end_of_text),
    .cfg_valid                    (cfg_valid),
    .cfg_ready                    (cfg_ready),
    .cfg_large_ascii_font_present (cfg_large_ascii_font_present)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic place_text_byte(input logic [7:0] b, input logic first,
                                 input logic [COL_W-1:0] sx, input logic last);
    logic               done;
    logic [CP_W-1:0]    cp;
    glyph_result_t      glyph;
    logic [WIDTH_W:0]   total;
    logic [COL_W-1:0]   advance;
    logic [WIDTH_W-1:0] add;
    done = 1'b0;
    cp = '0;
    if (first) begin
      cursor_col = sx;
      width_total = '0;
      partial_cp = '0;
      bytes_left = '0;
    end
    if (bytes_left != 0) begin
      partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
      bytes_left = bytes_left - 1'b1;
      if (bytes_left == 0) begin
        cp = partial_cp;
        done = 1'b1;
      end
    end else if (!b[7]) begin
      cp = CP_W'(b);
      done = 1'b1;
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      partial_cp = CP_W'(b & ~LEAD2_MASK);
      bytes_left = 2'd1;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      partial_cp = CP_W'(b & ~LEAD3_MASK);
      bytes_left = 2'd2;
    end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
      partial_cp = CP_W'(b & ~LEAD4_MASK);
      bytes_left = 2'd3;
    end else begin
      cp = CP_INVALID;
      done = 1'b1;
    end
    // text ends inside a sequence: missing bits are zero
    if (!done && last && bytes_left != 0) begin
      cp = partial_cp << (6 * bytes_left);
      bytes_left = '0;
      done = 1'b1;
    end
    if (done) begin
      partial_cp = '0;
      if (cp < CP_ASCII_LIM) begin
        if (font_large) begin
          glyph.glyph_kind = GLYPH_ASCII_LARGE;
          advance = ADV_LARGE;
        end else begin
          glyph.glyph_kind = GLYPH_ASCII_SMALL;
          advance = ADV_SMALL;
        end
        add = ADD_ASCII;
      end else begin
        if (cp == CP_FW_COMMA || cp == CP_IDEO_STOP || cp == CP_IDEO_COMMA) begin
          glyph.glyph_kind = GLYPH_SPECIAL;
        end else begin
          glyph.glyph_kind = GLYPH_WIDE;
        end
        advance = ADV_WIDE;
        add = ADD_WIDE;
      end
      total = width_total + add;
      width_total = total[WIDTH_W] ? '1 : total[WIDTH_W-1:0];
      glyph.codepoint = cp;
      glyph.draw_x = cursor_col;
      glyph.text_width = width_total - 1'b1;
      glyph.end_of_text = last;
      cursor_col = cursor_col + advance;
      expected_glyphs.push_back(glyph);
    end
  endtask

  task automatic send_text_byte(input logic [7:0] b, input logic first,
                                input logic [COL_W-1:0] sx, input logic last);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_first_byte <= first;
    in_start_x <= sx;
    in_last_byte <= last;
    do begin
      @(posedge clk);
      if (in_stall) input_stall_cycles++;
    end while (in_stall);
    place_text_byte(b, first, sx, last);
    bytes_sent++;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_font_register(input logic font_sel);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_large_ascii_font_present <= font_sel;
    do @(posedge clk); while (!cfg_ready);
    font_large = font_sel;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  function automatic logic [7:0] any_lead_byte();
    case ($urandom_range(0, 2))
      0:       return LEAD2_CODE | 8'($urandom_range(0, 31));
      1:       return LEAD3_CODE | 8'($urandom_range(0, 15));
      default: return LEAD4_CODE | 8'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic send_random_text();
    logic [7:0]       text_bytes[$];
    logic [COL_W-1:0] sx;
    int               n_chars;
    int               pick;
    bit               skip_first;
    bit               skip_last;
    n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    for (int c = 0; c < n_chars; c++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        text_bytes.push_back(8'($urandom_range(0, 127)));
      end else if (pick < 55) begin
        text_bytes.push_back(LEAD2_CODE | 8'($urandom_range(0, 31)));
        text_bytes.push_back(cont_byte());
      end else if (pick < 70) begin
        text_bytes.push_back(LEAD3_CODE | 8'($urandom_range(0, 15)));
        text_bytes.push_back(cont_byte());
        text_bytes.push_back(cont_byte());
      end else if (pick < 78) begin
        text_bytes.push_back(LEAD4_CODE | 8'($urandom_range(0, 7)));
        text_bytes.push_back(cont_byte());
        text_bytes.push_back(cont_byte());
        text_bytes.push_back(cont_byte());
      end else if (pick < 84) begin
        case ($urandom_range(0, 2))
          0: text_bytes = {text_bytes, 8'hEF, 8'hBC, 8'h8C};
          1: text_bytes = {text_bytes, 8'hE3, 8'h80, 8'h82};
          default: text_bytes = {text_bytes, 8'hE3, 8'h80, 8'h81};
        endcase
      end else if (pick < 90) begin
        if ($urandom_range(0, 1) == 0) text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
        else text_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
      end else begin
        // lead with no tail, the next char is swallowed as continuation
        text_bytes.push_back(any_lead_byte());
      end
    end
    if ($urandom_range(0, 4) == 0) text_bytes.push_back(any_lead_byte());
    case ($urandom_range(0, 5))
      0:       sx = 16'h8000;
      1:       sx = 16'h7FFF;
      default: sx = 16'($urandom);
    endcase
    skip_first = ($urandom_range(0, 19) == 0);
    skip_last = ($urandom_range(0, 19) == 0);
    foreach (text_bytes[i]) begin
      send_text_byte(text_bytes[i], i == 0 && !skip_first, (i == 0) ? sx : 16'($urandom),
                     i == text_bytes.size() - 1 && !skip_last);
    end
  endtask

  task automatic test_directed_bytes();
    logic [7:0] sample_text [24];
    sample_text = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'hF8, 8'hC3, 8'hA9, 8'hE3,
                    8'h80, 8'h82, 8'hE3, 8'h80, 8'h81, 8'hEF, 8'hBC, 8'h8C,
                    8'hF0, 8'h9F, 8'h98, 8'h80, 8'hC3, 8'h41, 8'hE4, 8'hF0};
    foreach (sample_text[i]) send_text_byte(sample_text[i], i == 0, 16'h7FFF, i == 23);
    send_text_byte(8'hF4, 1'b1, 16'h8000, 1'b1);
    send_text_byte(8'h31, 1'b0, 16'hFFFF, 1'b0);
  endtask

  task automatic test_random_texts();
    int target;
    for (int p = 0; p < 4; p++) begin
      write_font_register(p % 2 == 0);
      tx_gaps = (p != 2);
      rx_gaps = (p != 2);
      target = bytes_sent + 325;
      while (bytes_sent < target) send_random_text();
    end
  endtask

  task automatic test_backpressure();
    drain_results();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    @(posedge clk);
    hold_off_request = 60;
    for (int i = 0; i < 40; i++) begin
      send_text_byte(8'($urandom_range(0, 127)), i == 0, 16'($urandom), i == 39);
    end
    drain_results();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    for (int i = 0; i < 20; i++) send_random_text();
    drain_results();
  endtask

  task automatic test_wide_run();
    write_font_register(1'b1);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    // every byte closes a cut-short two-byte char, adding the wide width
    for (int i = 0; i < 200; i++) begin
      send_text_byte(LEAD2_CODE | 8'($urandom_range(2, 31)), i == 0, 16'($urandom), 1'b1);
    end
    for (int i = 0; i < 4; i++) send_text_byte(8'($urandom_range(0, 127)), 1'b0, 16'h0, 1'b0);
    write_font_register(1'b0);
  endtask

  always @(negedge clk) begin
    if (hold_off_request > 0) begin
      stall_left = hold_off_request;
      hold_off_request = 0;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (rx_gaps && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      if ($urandom_range(0, 19) == 0) stall_left = $urandom_range(10, 40);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    glyph_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      glyphs_checked++;
      if (expected_glyphs.size() == 0) begin
        $error("unexpected result item, codepoint %h", out_codepoint);
        error_count++;
      end else begin
        want = expected_glyphs.pop_front();
        if (out_codepoint !== want.codepoint) begin
          $error("codepoint: expected %h, got %h", want.codepoint, out_codepoint);
          error_count++;
        end
        if (out_draw_x !== want.draw_x) begin
          $error("draw_x: expected %0d, got %0d", $signed(want.draw_x), $signed(out_draw_x));
          error_count++;
        end
        if (out_glyph_kind !== want.glyph_kind) begin
          $error("glyph_kind: expected %0d, got %0d", want.glyph_kind, out_glyph_kind);
          error_count++;
        end
        if (out_text_width !== want.text_width) begin
          $error("text_width: expected %0d, got %0d", want.text_width, out_text_width);
          error_count++;
        end
        if (out_end_of_text !== want.end_of_text) begin
          $error("end_of_text: expected %0b, got %0b", want.end_of_text, out_end_of_text);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_text_byte = '0;
    in_first_byte = 1'b0;
    in_start_x = '0;
    in_last_byte = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_large_ascii_font_present = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_directed_bytes();
    test_random_texts();
    test_backpressure();
    test_wide_run();
    drain_results();
    repeat (10) @(posedge clk);
    $display("sent %0d text bytes, checked %0d glyph items with both font settings",
             bytes_sent, glyphs_checked);
    $display("input held off %0d cycles; a long run of wide glyphs and cut-short texts included",
             input_stall_cycles);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ utf8_text_layout_decoder_core.f @@
hw/rtl/utld_pkg.sv
hw/rtl/utld_byte_dec.sv
hw/rtl/utld_layout.sv
hw/rtl/utf8_text_layout_decoder_core.sv
tb/tb.sv
